FILE: src/rhc_pkg.sv
// Shared constants for the RGB/HSV converter.
`default_nettype none
package rhc_pkg;

  localparam logic [1:0] ModeToHsv   = 2'd0;
  localparam logic [1:0] ModeToRgb   = 2'd1;
  localparam logic [1:0] ModeRecolor = 2'd2;
  localparam logic [1:0] ModeUnused  = 2'd3;

  localparam logic CfgMode   = 1'b0;
  localparam logic CfgNewHue = 1'b1;

endpackage
`default_nettype wire

FILE: src/rhc_div.sv
// Pipelined restoring divider: 16-bit quotient, four bits resolved per stage.
`default_nettype none
module rhc_div import rhc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [15:0] num_i,
  input  wire logic [15:0] den_i,
  output logic      [15:0] quo_o
);
  logic [16:0] rem_q [4];
  logic [15:0] num_q [4];
  logic [15:0] den_q [4];
  logic [15:0] quo_q [4];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < 4; s++) begin
        logic [16:0] r;
        logic [15:0] n, d, qq;
        n  = (s == 0) ? num_i : num_q[s-1];
        d  = (s == 0) ? den_i : den_q[s-1];
        r  = (s == 0) ? 17'd0 : rem_q[s-1];
        qq = (s == 0) ? 16'd0 : quo_q[s-1];
        for (int k = 0; k < 4; k++) begin
          r = {r[15:0], n[15 - 4*s - k]};
          if (r >= {1'b0, d}) begin
            r = r - {1'b0, d};
            qq[15 - 4*s - k] = 1'b1;
          end
        end
        rem_q[s] <= r;
        num_q[s] <= n;
        den_q[s] <= d;
        quo_q[s] <= qq;
      end
    end
  end

  assign quo_o = quo_q[3];
endmodule
`default_nettype wire

FILE: src/rgb_hsv_color_converter.sv
// Top level of the RGB/HSV converter pipeline.
// One pixel per clock; a pixel accepted at one edge has its result on the ports, with done_o
// high, once it has passed through every stage (two front stages, four divider stages, five
// back stages; the accepting edge loads the first stage).
// busy never rises: the pipeline always advances, since the receiver cannot stall.
// Registers: index 0 mode, index 1 new_hue; write only while no pixel is in flight.
`default_nettype none
module rgb_hsv_color_converter import rhc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [8:0] chan_a_i,
  input  wire logic [7:0] chan_b_i,
  input  wire logic [7:0] chan_c_i,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic       cfg_index_i,
  input  wire logic [8:0] cfg_data_i,
  output logic            done_o,
  output logic      [8:0] res_a_o,
  output logic      [7:0] res_b_o,
  output logic      [7:0] res_c_o
);
  localparam int Depth = 11;

  localparam logic [1:0] CaseNone  = 2'd0;
  localparam logic [1:0] CaseRed   = 2'd1;
  localparam logic [1:0] CaseGreen = 2'd2;
  localparam logic [1:0] CaseBlue  = 2'd3;

  logic [1:0] mode_q;
  logic [8:0] new_hue_q;
  logic [Depth-1:0] vld_q;

  assign busy = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeToHsv;
      new_hue_q <= '0;
      vld_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == CfgMode) mode_q <= cfg_data_i[1:0];
        else new_hue_q <= cfg_data_i;
      end
      vld_q <= {vld_q[Depth-2:0], start};
    end
  end

  // stage 1: clamp, max/min, case select
  logic [7:0] r1_q, g1_q, b1_q, hi1_q, d1_q;
  logic [1:0] cs1_q;
  logic [8:0] ha1_q;
  logic [7:0] sa1_q, va1_q;
  always_ff @(posedge clk_i) begin
    logic [7:0] r, hi, lo;
    r  = (chan_a_i > 9'd255) ? 8'd255 : chan_a_i[7:0];
    hi = (r > chan_b_i) ? r : chan_b_i;  hi = (hi > chan_c_i) ? hi : chan_c_i;
    lo = (r < chan_b_i) ? r : chan_b_i;  lo = (lo < chan_c_i) ? lo : chan_c_i;
    r1_q <= r; g1_q <= chan_b_i; b1_q <= chan_c_i;
    hi1_q <= hi; d1_q <= hi - lo;
    cs1_q <= (hi == lo) ? CaseNone : (hi == r) ? CaseRed :
             (hi == chan_b_i) ? CaseGreen : CaseBlue;
    ha1_q <= chan_a_i; sa1_q <= chan_b_i; va1_q <= chan_c_i;
  end

  // stage 2: hue numerator, saturation numerator
  // 60*d + 60*(x - y) stays within 0..120*d; the per-case offset is added after the divide
  logic [15:0] hnum2_q, snum2_q;
  logic [7:0]  d2_q, hi2_q;
  logic [1:0]  cs2_q;
  logic [8:0]  ha2_q;
  logic [7:0]  sa2_q, va2_q;
  always_ff @(posedge clk_i) begin
    logic [15:0] base, pl, mi;
    case (cs1_q)
      CaseRed: begin pl = 16'(60) * g1_q; mi = 16'(60) * b1_q; end
      CaseGreen: begin pl = 16'(60) * b1_q; mi = 16'(60) * r1_q; end
      CaseBlue: begin pl = 16'(60) * r1_q; mi = 16'(60) * g1_q; end
      default: begin pl = '0; mi = '0; end
    endcase
    base = (cs1_q == CaseNone) ? 16'd0 : 16'(60) * d1_q;
    hnum2_q <= base + pl - mi;
    snum2_q <= 16'(100) * d1_q;
    d2_q <= (cs1_q == CaseNone) ? 8'd1 : d1_q;
    hi2_q <= (hi1_q == 8'd0) ? 8'd1 : hi1_q;
    cs2_q <= cs1_q; ha2_q <= ha1_q; sa2_q <= sa1_q; va2_q <= va1_q;
  end

  logic [15:0] hq, sq;
  rhc_div u_hdiv (.clk_i, .en_i(1'b1), .num_i(hnum2_q), .den_i({8'd0, d2_q}),
                  .quo_o(hq));
  rhc_div u_sdiv (.clk_i, .en_i(1'b1), .num_i(snum2_q), .den_i({8'd0, hi2_q}),
                  .quo_o(sq));

  // side delay for 4 divider stages
  logic [1:0] cs_d_q [4];
  logic [7:0] hi_d_q [4];
  logic [8:0] ha_d_q [4];
  logic [7:0] sa_d_q [4], va_d_q [4];
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      cs_d_q[i] <= (i == 0) ? cs2_q : cs_d_q[i-1];
      hi_d_q[i] <= (i == 0) ? hi2_q : hi_d_q[i-1];
      ha_d_q[i] <= (i == 0) ? ha2_q : ha_d_q[i-1];
      sa_d_q[i] <= (i == 0) ? sa2_q : sa_d_q[i-1];
      va_d_q[i] <= (i == 0) ? va2_q : va_d_q[i-1];
    end
  end

  // stage 7: finish forward HSV, pick back-path inputs
  logic [8:0] h7_q, bh7_q;
  logic [7:0] s7_q, v7_q, bs7_q, bv7_q;
  logic [1:0] md7_q;
  always_ff @(posedge clk_i) begin
    logic [8:0] h, hh;
    logic [7:0] s, v, ss, vv;
    logic [15:0] hm;
    case (cs_d_q[3])
      CaseRed: hm = hq + 16'd300;
      CaseGreen: hm = hq + 16'd60;
      CaseBlue: hm = hq + 16'd180;
      default: hm = '0;
    endcase
    if (hm >= 16'd360) hm = hm - 16'd360;
    h  = hm[8:0];
    s  = (cs_d_q[3] == CaseNone) ? 8'd0 : sq[7:0];
    // x/255 as ((x + 1) * 257) >> 16, exact for x up to 25500; the zero guard still gives 0
    v  = 8'(((32'(hi_d_q[3]) * 32'd100 + 32'd1) * 32'd257) >> 16);
    if (mode_q == ModeToRgb) begin
      hh = (ha_d_q[3] >= 9'd360) ? ha_d_q[3] - 9'd360 : ha_d_q[3];
      ss = (sa_d_q[3] > 8'd100) ? 8'd100 : sa_d_q[3];
      vv = (va_d_q[3] > 8'd100) ? 8'd100 : va_d_q[3];
    end else begin
      hh = (new_hue_q >= 9'd360) ? new_hue_q - 9'd360 : new_hue_q;
      ss = s;
      vv = v;
    end
    h7_q <= h; s7_q <= s; v7_q <= v;
    bh7_q <= hh; bs7_q <= ss; bv7_q <= vv; md7_q <= mode_q;
  end

  // stage 8: sextant, fraction, products
  logic [2:0] sx8_q;
  logic [15:0] pn8_q, qn8_q, tn8_q;
  logic [14:0] fn8_q;
  logic [7:0] bv8_q;
  logic [8:0] h8_q;
  logic [7:0] s8_q, v8_q;
  logic [1:0] md8_q;
  always_ff @(posedge clk_i) begin
    logic [2:0] sx;
    logic [5:0] fr;
    if (bh7_q < 9'd60) sx = 3'd0;
    else if (bh7_q < 9'd120) sx = 3'd1;
    else if (bh7_q < 9'd180) sx = 3'd2;
    else if (bh7_q < 9'd240) sx = 3'd3;
    else if (bh7_q < 9'd300) sx = 3'd4;
    else sx = 3'd5;
    fr = 6'(bh7_q - 9'(sx) * 9'd60);
    sx8_q <= sx;
    pn8_q <= 16'(bv7_q) * 16'(8'd100 - bs7_q);
    qn8_q <= 16'(6000) - 16'(fr) * 16'(bs7_q);
    tn8_q <= 16'(6000) - 16'(6'd60 - fr) * 16'(bs7_q);
    fn8_q <= 15'(255) * 15'(bv7_q);
    bv8_q <= bv7_q;
    h8_q <= h7_q; s8_q <= s7_q; md8_q <= md7_q;
    v8_q <= v7_q;
  end

  // stage 9: wide numerators
  logic [31:0] qw9_q, tw9_q;
  logic [23:0] pw9_q;
  logic [14:0] fn9_q;
  logic [2:0] sx9_q;
  logic [8:0] h9_q;
  logic [7:0] s9_q, v9_q;
  logic [1:0] md9_q;
  always_ff @(posedge clk_i) begin
    qw9_q <= 32'(fn8_q) * 32'(qn8_q);
    tw9_q <= 32'(fn8_q) * 32'(tn8_q);
    pw9_q <= 24'(255) * 24'(pn8_q);
    fn9_q <= fn8_q; sx9_q <= sx8_q;
    h9_q <= h8_q; s9_q <= s8_q; v9_q <= v8_q; md9_q <= md8_q;
  end

  // stage 10: constant divides by reciprocal multiply
  logic [7:0] fu10_q, p10_q, q10_q, t10_q;
  logic [2:0] sx10_q;
  logic [8:0] h10_q;
  logic [7:0] s10_q, v10_q;
  logic [1:0] md10_q;
  always_ff @(posedge clk_i) begin
    logic [63:0] qe, te;
    logic [47:0] pe;
    logic [31:0] fe;
    fe = 32'(fn9_q) * 32'd41944;          // /100, exact up to 25500
    pe = 48'(pw9_q) * 48'd6871948;        // /10000, exact below 2^24
    qe = 64'(qw9_q) * 64'd117281241;      // /600000, exact up to 153000000
    te = 64'(tw9_q) * 64'd117281241;
    fu10_q <= 8'(fe >> 22);
    p10_q  <= 8'(pe >> 36);
    q10_q  <= 8'(qe >> 46);
    t10_q  <= 8'(te >> 46);
    sx10_q <= sx9_q; h10_q <= h9_q; s10_q <= s9_q; v10_q <= v9_q; md10_q <= md9_q;
  end

  // stage 11: output select
  logic [8:0] ra_q;
  logic [7:0] rb_q, rc_q;
  always_ff @(posedge clk_i) begin
    logic [7:0] x, y, z;
    case (sx10_q)
      3'd0: begin x = fu10_q; y = t10_q;  z = p10_q;  end
      3'd1: begin x = q10_q;  y = fu10_q; z = p10_q;  end
      3'd2: begin x = p10_q;  y = fu10_q; z = t10_q;  end
      3'd3: begin x = p10_q;  y = q10_q;  z = fu10_q; end
      3'd4: begin x = t10_q;  y = p10_q;  z = fu10_q; end
      default: begin x = fu10_q; y = p10_q; z = q10_q; end
    endcase
    case (md10_q)
      ModeToHsv: begin ra_q <= h10_q; rb_q <= s10_q; rc_q <= v10_q; end
      ModeToRgb, ModeRecolor: begin ra_q <= {1'b0, x}; rb_q <= y; rc_q <= z; end
      default: begin ra_q <= '0; rb_q <= '0; rc_q <= '0; end
    endcase
  end

  assign done_o  = vld_q[Depth-1];
  assign res_a_o = ra_q;
  assign res_b_o = rb_q;
  assign res_c_o = rc_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && mode_q == ModeToHsv |-> res_a_o < 9'd360)
    else $error("hue out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##Depth done_o)
    else $error("result lost");
endmodule
`default_nettype wire
